// ----- rtl/core/mtc_pkg.sv -----
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types and constants for the magnetometer trim compensation pipeline.
// ----------------------------------------------------------------------------
package mtc_pkg;

    // output fraction bits default
    localparam int MTC_OUT_FRAC_BITS = 8;

    // datapath widths
    localparam int RAW_W  = 24;
    localparam int R_W    = 21;  // reading after >>3
    localparam int A_W    = 49;  // corrected axis numerator
    localparam int B_W    = 29;  // temperature gain factor
    localparam int P_W    = 77;  // A*B
    localparam int N_W    = 90;  // cross-axis combined sum
    localparam int F_W    = 32;  // field output
    localparam int TEMP_W = 22;

    // configuration register indexes
    localparam logic [2:0] REG_TEMP_TRIM = 3'd0;
    localparam logic [2:0] REG_SENS_TRIM = 3'd1;
    localparam logic [2:0] REG_OFFS_TRIM = 3'd2;
    localparam logic [2:0] REG_TCO_TRIM  = 3'd3;
    localparam logic [2:0] REG_TCS_TRIM  = 3'd4;
    localparam logic [2:0] REG_CROSS     = 3'd5;

    localparam int CFG_W = 48;

    typedef struct packed {
        logic [RAW_W-1:0] raw_t;
        logic [RAW_W-1:0] raw_z;
        logic [RAW_W-1:0] raw_y;
        logic [RAW_W-1:0] raw_x;
    } t_sample;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic signed [F_W-1:0]    field_z;
        logic signed [F_W-1:0]    field_y;
        logic signed [F_W-1:0]    field_x;
    } t_result;

endpackage

// ----- rtl/core/mtc_front.sv -----
// ----------------------------------------------------------------------------
// mtc_front
// Per-axis trim correction: builds A (sensitivity, offset, temp offset) and
// B (temperature gain) over two register stages.
// ----------------------------------------------------------------------------
module mtc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [mtc_pkg::R_W-1:0]   i_r,
    input  logic signed [mtc_pkg::R_W-1:0]   i_t,
    input  logic        [15:0]               i_sens,
    input  logic        [15:0]               i_offs,
    input  logic        [7:0]                i_tco,
    input  logic        [7:0]                i_tcs,
    output logic                             o_valid,
    output logic signed [mtc_pkg::A_W-1:0]   o_a,
    output logic signed [mtc_pkg::B_W-1:0]   o_b
);
    import mtc_pkg::*;

    logic signed [16:0] sens_gain;
    logic signed [37:0] n_m1, r_m1;
    logic signed [28:0] n_ct, r_ct;
    logic signed [28:0] n_tt, r_tt;
    logic signed [15:0] r_offs;
    logic               r_v1, r_v2;
    logic signed [A_W-1:0] n_a, r_a;
    logic signed [B_W-1:0] n_b, r_b;

    // stage 1: products
    assign sens_gain = $signed({i_sens[15], i_sens}) + 17'sd256;
    assign n_m1 = i_r * sens_gain;
    assign n_ct = $signed(i_tco) * i_t;
    assign n_tt = $signed(i_tcs) * i_t;

    // stage 2: sums
    assign n_a = (A_W'(r_m1) <<< 11) + (A_W'(r_offs) <<< 18) + A_W'(r_ct);
    assign n_b = 29'sd8388608 + r_tt;

    always_ff @(posedge i_clk) begin
        r_m1   <= n_m1;
        r_ct   <= n_ct;
        r_tt   <= n_tt;
        r_offs <= $signed(i_offs);
        r_a    <= n_a;
        r_b    <= n_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_a     = r_a;
    assign o_b     = r_b;

endmodule

// ----- rtl/core/mtc_mul.sv -----
// ----------------------------------------------------------------------------
// mtc_mul
// A*B product split into two 25x29 partial products, summed next stage.
// ----------------------------------------------------------------------------
module mtc_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [mtc_pkg::A_W-1:0]   i_a,
    input  logic signed [mtc_pkg::B_W-1:0]   i_b,
    output logic                             o_valid,
    output logic signed [mtc_pkg::P_W-1:0]   o_p
);
    import mtc_pkg::*;

    logic signed [53:0] n_pl, r_pl, n_ph, r_ph;
    logic signed [P_W-1:0] n_p, r_p;
    logic r_v1, r_v2;

    // stage 1: low half unsigned, high half signed
    assign n_pl = $signed({1'b0, i_a[23:0]}) * i_b;
    assign n_ph = $signed(i_a[A_W-1:24]) * i_b;

    // stage 2: recombine
    assign n_p = (P_W'(r_ph) <<< 24) + P_W'(r_pl);

    always_ff @(posedge i_clk) begin
        r_pl <= n_pl;
        r_ph <= n_ph;
        r_p  <= n_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_p     = r_p;

endmodule

// ----- rtl/core/mtc_combine.sv -----
// ----------------------------------------------------------------------------
// mtc_combine
// Cross-axis correction: 800*own axis minus trimmed neighbor terms (x subtracts y and z terms, y a z term, z none).
// ----------------------------------------------------------------------------
module mtc_combine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [mtc_pkg::P_W-1:0]   i_px,
    input  logic signed [mtc_pkg::P_W-1:0]   i_py,
    input  logic signed [mtc_pkg::P_W-1:0]   i_pz,
    input  logic        [23:0]               i_cross,
    output logic                             o_valid,
    output logic signed [mtc_pkg::N_W-1:0]   o_nx,
    output logic signed [mtc_pkg::N_W-1:0]   o_ny,
    output logic signed [mtc_pkg::N_W-1:0]   o_nz
);
    import mtc_pkg::*;

    logic signed [N_W-1:0] n_wx, n_wy, n_wz, n_kyx, n_kzx, n_kzy;
    logic signed [N_W-1:0] r_wx, r_wy, r_wz, r_kyx, r_kzx, r_kzy;
    logic signed [N_W-1:0] r_nx, r_ny, r_nz;
    logic r_v1, r_v2;

    // stage 1: 800 = 512 + 256 + 32, trim products at full width
    assign n_wx = (N_W'(i_px) <<< 9) + (N_W'(i_px) <<< 8) + (N_W'(i_px) <<< 5);
    assign n_wy = (N_W'(i_py) <<< 9) + (N_W'(i_py) <<< 8) + (N_W'(i_py) <<< 5);
    assign n_wz = (N_W'(i_pz) <<< 9) + (N_W'(i_pz) <<< 8) + (N_W'(i_pz) <<< 5);
    assign n_kyx = $signed(i_cross[7:0])   * N_W'(i_py);
    assign n_kzx = $signed(i_cross[15:8])  * N_W'(i_pz);
    assign n_kzy = $signed(i_cross[23:16]) * N_W'(i_pz);

    always_ff @(posedge i_clk) begin
        r_wx  <= n_wx;
        r_wy  <= n_wy;
        r_wz  <= n_wz;
        r_kyx <= n_kyx;
        r_kzx <= n_kzx;
        r_kzy <= n_kzy;
        // stage 2: subtract cross terms
        r_nx  <= r_wx - r_kyx - r_kzx;
        r_ny  <= r_wy - r_kzy;
        r_nz  <= r_wz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_nx    = r_nx;
    assign o_ny    = r_ny;
    assign o_nz    = r_nz;

endmodule

// ----- rtl/core/mtc_round.sv -----
// ----------------------------------------------------------------------------
// mtc_round
// Scale by 5/2^s, round half away from zero, saturate to 32 bits signed.
// ----------------------------------------------------------------------------
module mtc_round #(
    parameter int OUT_FRAC_BITS = mtc_pkg::MTC_OUT_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [mtc_pkg::N_W-1:0]   i_n,
    output logic                             o_valid,
    output logic signed [mtc_pkg::F_W-1:0]   o_field
);
    import mtc_pkg::*;

    localparam int SH   = 63 - OUT_FRAC_BITS;
    localparam int M_W  = N_W + 3;

    logic [M_W-1:0] mag, n_m, r_m, q;
    logic           r_neg;
    logic signed [F_W-1:0] n_f, r_f;
    logic r_v1, r_v2;

    // stage 1: magnitude times 5 plus half LSB
    assign mag = i_n[N_W-1] ? M_W'(-i_n) : M_W'(i_n);
    assign n_m = (mag << 2) + mag + (M_W'(1) << (SH - 1));

    // stage 2: shift, sign and clamp
    assign q = r_m >> SH;
    always_comb begin
        if (r_neg) begin
            if (q > M_W'(33'h080000000)) n_f = 32'sh80000000;
            else                        n_f = -$signed(q[F_W-1:0]);
        end else begin
            if (q > M_W'(32'h7FFFFFFF)) n_f = 32'sh7FFFFFFF;
            else                        n_f = $signed(q[F_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_m   <= n_m;
        r_neg <= i_n[N_W-1];
        r_f   <= n_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_field = r_f;

endmodule

// ----- rtl/core/magnetometer_trim_compensation.sv -----
// ----------------------------------------------------------------------------
// magnetometer_trim_compensation
// start to o_valid runs through front, mul, combine and round; one sample accepted every cycle.
// Throughput is set by the fully pipelined multiplier stages (no shared unit).
// busy is always low; results are strobed for one cycle, no stall.
// Synchronous active-low reset clears trims to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module magnetometer_trim_compensation #(
    parameter int OUT_FRAC_BITS = mtc_pkg::MTC_OUT_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  mtc_pkg::t_sample              i_sample,
    output logic                          o_valid,
    output mtc_pkg::t_result              o_result,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_addr,
    input  logic [mtc_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import mtc_pkg::*;

    localparam int LAT = 8;

    logic [7:0]  r_temp_trim;
    logic [47:0] r_sens, r_offs;
    logic [23:0] r_tco, r_tcs, r_cross;

    logic accept;
    logic signed [R_W-1:0] t_s, rx, ry, rz;
    logic signed [TEMP_W-1:0] n_temp;
    logic signed [TEMP_W-1:0] r_temp [LAT];

    logic fv_x, fv_y, fv_z, mv_x, mv_y, mv_z, cv;
    logic signed [A_W-1:0] a_x, a_y, a_z;
    logic signed [B_W-1:0] b_x, b_y, b_z;
    logic signed [P_W-1:0] p_x, p_y, p_z;
    logic signed [N_W-1:0] n_x, n_y, n_z;
    logic signed [F_W-1:0] f_x, f_y, f_z;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim <= '0;
            r_sens      <= '0;
            r_offs      <= '0;
            r_tco       <= '0;
            r_tcs       <= '0;
            r_cross     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_TEMP_TRIM: r_temp_trim <= i_cfg_wdata[7:0];
                REG_SENS_TRIM: r_sens      <= i_cfg_wdata[47:0];
                REG_OFFS_TRIM: r_offs      <= i_cfg_wdata[47:0];
                REG_TCO_TRIM:  r_tco       <= i_cfg_wdata[23:0];
                REG_TCS_TRIM:  r_tcs       <= i_cfg_wdata[23:0];
                REG_CROSS:     r_cross     <= i_cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // drop the three low bits of each reading
    assign rx  = $signed(i_sample.raw_x[RAW_W-1:3]);
    assign ry  = $signed(i_sample.raw_y[RAW_W-1:3]);
    assign rz  = $signed(i_sample.raw_z[RAW_W-1:3]);
    assign t_s = $signed(i_sample.raw_t[RAW_W-1:3]);

    // temperature is exact, just delayed to line up with the fields
    assign n_temp = TEMP_W'(t_s) +
                    ((TEMP_W'($signed(r_temp_trim)) + 22'sd23) <<< 9);

    always_ff @(posedge i_clk) begin
        r_temp[0] <= n_temp;
        for (int i = 1; i < LAT; i++) r_temp[i] <= r_temp[i-1];
    end

    mtc_front u_front_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept), .i_r(rx), .i_t(t_s),
        .i_sens(r_sens[15:0]), .i_offs(r_offs[15:0]),
        .i_tco(r_tco[7:0]), .i_tcs(r_tcs[7:0]),
        .o_valid(fv_x), .o_a(a_x), .o_b(b_x)
    );
    mtc_front u_front_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept), .i_r(ry), .i_t(t_s),
        .i_sens(r_sens[31:16]), .i_offs(r_offs[31:16]),
        .i_tco(r_tco[15:8]), .i_tcs(r_tcs[15:8]),
        .o_valid(fv_y), .o_a(a_y), .o_b(b_y)
    );
    mtc_front u_front_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept), .i_r(rz), .i_t(t_s),
        .i_sens(r_sens[47:32]), .i_offs(r_offs[47:32]),
        .i_tco(r_tco[23:16]), .i_tcs(r_tcs[23:16]),
        .o_valid(fv_z), .o_a(a_z), .o_b(b_z)
    );

    mtc_mul u_mul_x (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(fv_x),
        .i_a(a_x), .i_b(b_x), .o_valid(mv_x), .o_p(p_x));
    mtc_mul u_mul_y (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(fv_y),
        .i_a(a_y), .i_b(b_y), .o_valid(mv_y), .o_p(p_y));
    mtc_mul u_mul_z (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(fv_z),
        .i_a(a_z), .i_b(b_z), .o_valid(mv_z), .o_p(p_z));

    mtc_combine u_combine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(mv_x & mv_y & mv_z),
        .i_px(p_x), .i_py(p_y), .i_pz(p_z), .i_cross(r_cross),
        .o_valid(cv), .o_nx(n_x), .o_ny(n_y), .o_nz(n_z)
    );

    mtc_round #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_round_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(cv), .i_n(n_x),
        .o_valid(o_valid), .o_field(f_x));
    mtc_round #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_round_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(cv), .i_n(n_y),
        .o_valid(), .o_field(f_y));
    mtc_round #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_round_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(cv), .i_n(n_z),
        .o_valid(), .o_field(f_z));

    assign o_result.field_x     = f_x;
    assign o_result.field_y     = f_y;
    assign o_result.field_z     = f_z;
    assign o_result.temperature = r_temp[LAT-1];

endmodule
